// ----- sv/rvhp_pkg.sv -----
// Package for the radar video record header parser.
// Holds the channel payload types, phase and code constants, and the item-walk functions.
// No dependencies.
package rvhp_pkg;

    // Octets of video per repetition unit.
    localparam int VIDEO_UNIT_BYTES = 64;

    // Result queue depth (power of two).
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam int NUM_ITEM_KINDS = 13;
    localparam int ITEM_BASE      = 5;

    // Field kinds
    localparam logic [3:0] KIND_MSGTYPE = 4'd2;
    localparam logic [3:0] KIND_COMPR   = 4'd8;
    localparam logic [3:0] KIND_REP     = 4'd12;
    localparam logic [3:0] KIND_VIDEO   = 4'd13;
    localparam logic [3:0] KIND_STATUS  = 4'd14;

    // Status codes
    localparam logic [31:0] ST_DELIVERED  = 32'd0;
    localparam logic [31:0] ST_LENGTH_BAD = 32'd1;
    localparam logic [31:0] ST_NOT_VIDEO  = 32'd2;
    localparam logic [31:0] ST_TRUNCATED  = 32'd3;

    localparam logic [7:0]  MSG_VIDEO     = 8'd2;
    localparam logic [15:0] COUNT_SAT     = 16'hFFFF;

    typedef enum logic [4:0] {
        PH_CAT    = 5'd0,
        PH_LENH   = 5'd1,
        PH_LENL   = 5'd2,
        PH_FS0    = 5'd3,
        PH_FS1    = 5'd4,
        PH_ITEM0  = 5'd5,
        PH_ITEM1  = 5'd6,
        PH_ITEM2  = 5'd7,
        PH_ITEM3  = 5'd8,
        PH_ITEM4  = 5'd9,
        PH_ITEM5  = 5'd10,
        PH_ITEM6  = 5'd11,
        PH_ITEM7  = 5'd12,
        PH_ITEM8  = 5'd13,
        PH_ITEM9  = 5'd14,
        PH_ITEM10 = 5'd15,
        PH_ITEM11 = 5'd16,
        PH_ITEM12 = 5'd17,
        PH_VIDEO  = 5'd18,
        PH_SKIP   = 5'd19,
        PH_DONE   = 5'd20
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [31:0] field_value;
        logic        is_final;
    } out_item_t;

    // Results produced by one accepted octet: count, then up to two items in order.
    typedef struct packed {
        logic [1:0] n;
        out_item_t  first;
        out_item_t  second;
    } res_push_t;

    typedef struct packed {
        phase_t phase;
        logic   pend_load;
    } adv_t;

    // Octets in each data field.
    function automatic logic [2:0] item_len(input logic [3:0] k);
        logic [2:0] len;
        case (k)
            4'd3, 4'd6, 4'd7: len = 3'd4;
            4'd4, 4'd5, 4'd10: len = 3'd2;
            4'd11: len = 3'd3;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    // Whether the FSPEC bits announce the item carrying field kind k.
    function automatic logic kind_present(input int k, input logic [7:0] f0,
                                          input logic [7:0] f1);
        logic p;
        if (k <= 1)       p = f0[7];
        else if (k == 2)  p = f0[6];
        else if (k == 3)  p = f0[5];
        else if (k <= 7)  p = f0[3] | f0[2];
        else if (k <= 9)  p = f0[1];
        else if (k <= 11) p = f1[7];
        else              p = ~f1[6] & f1[5];
        return p;
    endfunction

    // Find the next announced field from kind start; stop at the type decision.
    function automatic adv_t advance_from(input logic [3:0] start, input logic [7:0] f0,
                                          input logic [7:0] f1, input logic [7:0] pend,
                                          input logic [7:0] comm);
        adv_t       res;
        logic       found;
        logic [7:0] p;
        res.phase     = PH_DONE;
        res.pend_load = 1'b0;
        found         = 1'b0;
        p             = pend;
        for (int j = 0; j < NUM_ITEM_KINDS; j++) begin
            if (!found && j >= int'(start)) begin
                if (j == 2 && !f0[6]) begin
                    res.pend_load = 1'b1;
                    p             = comm;
                end
                if (j == 3 && p != MSG_VIDEO) begin
                    res.phase = PH_SKIP;
                    found     = 1'b1;
                end else if (kind_present(j, f0, f1)) begin
                    res.phase = phase_t'(5'(j + ITEM_BASE));
                    found     = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/rvhp_parse.sv -----
// Octet parser: header, FSPEC-driven field walk, video octets and closing status.
// Depends on rvhp_pkg.
module rvhp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  rvhp_pkg::in_item_t   item,
    output rvhp_pkg::res_push_t  push
);
    import rvhp_pkg::*;

    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] dl_reg, dl_next;
    logic [7:0]  fs0_reg, fs0_next;
    logic [7:0]  fs1_reg, fs1_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  pend_reg, pend_next;
    logic [7:0]  comm_reg, comm_next;
    logic [14:0] vleft_reg, vleft_next;

    logic [7:0]  b;
    logic [31:0] acc_shift;
    logic [2:0]  idx_inc;
    logic [3:0]  k;
    logic [15:0] prod;
    logic [14:0] vleft_dec;
    logic        good;
    logic [31:0] status;
    adv_t        adv;
    out_item_t   field_res;
    logic        field_hit;

    assign b         = item.data_byte;
    assign acc_shift = {acc_reg[23:0], b};
    assign idx_inc   = idx_reg + 3'd1;
    assign k         = 4'(phase_reg - PH_ITEM0);
    assign prod      = 16'(b) * 16'(VIDEO_UNIT_BYTES);
    assign vleft_dec = (vleft_reg != 15'd0) ? vleft_reg - 15'd1 : vleft_reg;

    // Advance parse state for one octet
    always_comb
    begin
        cnt_next   = (cnt_reg != COUNT_SAT) ? cnt_reg + 16'd1 : cnt_reg;
        dl_next    = dl_reg;
        fs0_next   = fs0_reg;
        fs1_next   = fs1_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        comm_next  = comm_reg;
        vleft_next = vleft_reg;
        field_hit  = 1'b0;
        field_res  = '0;
        adv        = '0;
        good       = 1'b0;
        status     = ST_DELIVERED;

        case (phase_reg)
            PH_CAT:  phase_next = PH_LENH;
            PH_LENH:
            begin
                dl_next    = {b, 8'h00};
                phase_next = PH_LENL;
            end
            PH_LENL:
            begin
                dl_next    = dl_reg | {8'h00, b};
                phase_next = PH_FS0;
            end
            PH_FS0:
            begin
                fs0_next   = b;
                phase_next = PH_FS1;
            end
            PH_FS1:
            begin
                fs1_next   = b;
                adv        = advance_from(4'd0, fs0_reg, b, pend_reg, comm_reg);
                phase_next = adv.phase;
                if (adv.pend_load)
                    pend_next = comm_reg;
            end
            PH_VIDEO:
            begin
                field_hit             = 1'b1;
                field_res.field_kind  = KIND_VIDEO;
                field_res.field_value = {24'h0, b};
                vleft_next            = vleft_dec;
                if (vleft_dec == 15'd0)
                    phase_next = PH_DONE;
            end
            PH_SKIP, PH_DONE: ;
            default:
            begin
                if (phase_reg >= PH_ITEM0 && phase_reg <= PH_ITEM12) begin
                    if (idx_inc >= item_len(k)) begin
                        // Field complete: emit it and look for the next one
                        field_hit             = 1'b1;
                        field_res.field_kind  = k;
                        field_res.field_value = (k == KIND_COMPR) ?
                                                {31'h0, acc_shift[7]} : acc_shift;
                        idx_next = 3'd0;
                        acc_next = 32'd0;
                        if (k == KIND_MSGTYPE)
                            pend_next = b;
                        if (k == KIND_REP) begin
                            vleft_next = prod[14:0];
                            phase_next = (prod[14:0] != 15'd0) ? PH_VIDEO : PH_DONE;
                        end else begin
                            adv = advance_from(k + 4'd1, fs0_reg, fs1_reg,
                                               (k == KIND_MSGTYPE) ? b : pend_reg,
                                               comm_reg);
                            phase_next = adv.phase;
                            if (adv.pend_load)
                                pend_next = comm_reg;
                        end
                    end else begin
                        idx_next = idx_inc;
                        acc_next = acc_shift;
                    end
                end else begin
                    phase_next = PH_DONE;
                end
            end
        endcase

        // Close the datagram: status, type commit, clear per-datagram state
        if (item.end_of_datagram) begin
            good = (cnt_reg != COUNT_SAT) && ({1'b0, cnt_reg} + 17'd1 == {1'b0, dl_next});
            if (!good)
                status = ST_LENGTH_BAD;
            else if (phase_next <= PH_VIDEO)
                status = ST_TRUNCATED;
            else if (phase_next == PH_SKIP)
                status = ST_NOT_VIDEO;
            else
                status = ST_DELIVERED;
            if (good && phase_next >= PH_ITEM3)
                comm_next = pend_next;
            cnt_next   = 16'd0;
            dl_next    = 16'd0;
            fs0_next   = 8'd0;
            fs1_next   = 8'd0;
            phase_next = PH_CAT;
            idx_next   = 3'd0;
            acc_next   = 32'd0;
            vleft_next = 15'd0;
        end
    end

    // Pack the results of this octet in order
    always_comb
    begin
        push = '0;
        if (accept) begin
            if (field_hit) begin
                push.first = field_res;
                if (item.end_of_datagram) begin
                    push.n                  = 2'd2;
                    push.second.field_kind  = KIND_STATUS;
                    push.second.field_value = status;
                    push.second.is_final    = 1'b1;
                end else begin
                    push.n = 2'd1;
                end
            end else if (item.end_of_datagram) begin
                push.n                 = 2'd1;
                push.first.field_kind  = KIND_STATUS;
                push.first.field_value = status;
                push.first.is_final    = 1'b1;
            end
        end
    end

    // Hold state unless an octet is accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg   <= 16'd0;
            dl_reg    <= 16'd0;
            fs0_reg   <= 8'd0;
            fs1_reg   <= 8'd0;
            phase_reg <= PH_CAT;
            idx_reg   <= 3'd0;
            acc_reg   <= 32'd0;
            pend_reg  <= 8'd0;
            comm_reg  <= 8'd0;
            vleft_reg <= 15'd0;
        end else if (accept) begin
            cnt_reg   <= cnt_next;
            dl_reg    <= dl_next;
            fs0_reg   <= fs0_next;
            fs1_reg   <= fs1_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            comm_reg  <= comm_next;
            vleft_reg <= vleft_next;
        end
    end

    a_video_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VIDEO |-> vleft_reg != 15'd0)
        else $error("video phase with no octets left");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.end_of_datagram |=> phase_reg == PH_CAT && cnt_reg == 16'd0)
        else $error("datagram state not cleared after final octet");

    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> push.second.is_final && !push.first.is_final &&
                           push.first.field_kind != KIND_STATUS)
        else $error("second result is not the closing status");

endmodule

// ----- sv/rvhp_outq.sv -----
// Result queue: takes up to two results per cycle, delivers one per transaction.
// Depends on rvhp_pkg.
module rvhp_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rvhp_pkg::res_push_t  push,
    output logic                 space_ok,
    output logic                 result_valid,
    input  logic                 result_stall,
    output rvhp_pkg::out_item_t  result
);
    import rvhp_pkg::*;

    out_item_t           mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_reg, wr_next;
    logic [OQ_PTR_W-1:0] rd_reg, rd_next;
    logic [OQ_CNT_W-1:0] count_reg, count_next;
    logic                pop;

    assign pop          = result_valid && !result_stall;
    assign result_valid = count_reg != '0;
    assign result       = mem[rd_reg];
    // Leave room for the two results one octet can produce
    assign space_ok     = count_reg <= OQ_CNT_W'(OQ_DEPTH - 2);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next    = wr_reg + OQ_PTR_W'(push.n);
        rd_next    = pop ? rd_reg + OQ_PTR_W'(1) : rd_reg;
        count_next = count_reg + OQ_CNT_W'(push.n) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Store pushed results in order
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_reg] <= push.first;
        if (push.n == 2'd2)
            mem[wr_reg + OQ_PTR_W'(1)] <= push.second;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> count_reg <= OQ_CNT_W'(OQ_DEPTH - 2))
        else $error("results pushed without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd0 && !pop |=> $stable(count_reg))
        else $error("occupancy changed without a transaction");

endmodule

// ----- sv/radar_video_record_header_parser.sv -----
// Radar video record header parser: one octet per transaction in, tagged fields out.
// Results are registered in the result queue and offered in order; the closing status
// on a final octet that also yields a field is offered after that field.
// Throughput: one octet per cycle; the four-entry result queue stalls input while it
// holds more than two results. Reset clears the parse state, both message types and
// the queue.
// Depends on rvhp_pkg, rvhp_parse, rvhp_outq.
module radar_video_record_header_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  rvhp_pkg::in_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output rvhp_pkg::out_item_t  result
);
    import rvhp_pkg::*;

    res_push_t push;
    logic      space_ok;
    logic      accept;

    // Accept an octet when the queue can take both of its results
    assign item_stall = !space_ok;
    assign accept     = item_valid && !item_stall;

    rvhp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push)
    );

    rvhp_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space_ok     (space_ok),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
